### sv/sfs_pkg.sv
// Shared types and constants of the sprite frame sequencer.
package sfs_pkg;

	localparam int unsigned PosW     = 9;
	localparam int unsigned LenW     = 10;
	localparam int unsigned AccW     = 17;
	localparam int unsigned PixW     = 14;
	localparam int unsigned LIST_DEPTH_DEF = 64;
	localparam int unsigned MAX_FRAMES_DEF = 256;
	localparam logic [AccW-1:0] AccMax = 17'h1FFFF;

	typedef enum logic [2:0] {
		OP_TICK   = 3'd0,
		OP_BEGIN  = 3'd1,
		OP_HALT   = 3'd2,
		OP_PAUSE  = 3'd3,
		OP_RESUME = 3'd4,
		OP_LOAD   = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		REG_FRAME_WIDTH   = 3'd0,
		REG_FRAME_HEIGHT  = 3'd1,
		REG_FRAMES_ACROSS = 3'd2,
		REG_FRAMES_DOWN   = 3'd3,
		REG_FRAME_PERIOD  = 3'd4,
		REG_PLAY_MODE     = 3'd5,
		REG_RANGE_START   = 3'd6,
		REG_RANGE_STOP    = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		SRC_SHEET = 2'd0,
		SRC_RANGE = 2'd1,
		SRC_LIST  = 2'd2,
		SRC_ALT   = 2'd3
	} src_t;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_EXEC = 9'b000000010,
		ST_TCHK = 9'b000000100,
		ST_LOOK = 9'b000001000,
		ST_FN   = 9'b000010000,
		ST_DIV  = 9'b000100000,
		ST_MULX = 9'b001000000,
		ST_MULY = 9'b010000000,
		ST_PUT  = 9'b100000000
	} state_t;

	function automatic logic [4:0] clamp16(input logic [4:0] v);
		logic [4:0] r;
		r = v;
		if (v == 5'd0) begin
			r = 5'd1;
		end else if (v > 5'd16) begin
			r = 5'd16;
		end
		return r;
	endfunction

endpackage

### sv/sprite_frame_sequencer.sv
// Sprite sheet frame sequencer: playback control, list memory and position unit.
//
// Usage: configuration registers are written through cfg_we, cfg_index and
// cfg_data while the block is idle. Commands arrive as beats on the input
// channel (in_valid/in_ready) and every command beat yields exactly one
// result beat on the output channel (out_valid/out_ready) carrying the frame
// shown, its sheet position, the playing flag and the done pulse.
// A command runs from acceptance to a valid result through EXEC, then TCHK for a tick
// while playing, which adds the period check, then LOOK and FN, eight steps
// of the shared restoring divider that splits the frame number into column and
// row, and two passes through the one shared multiplier for the x and y
// positions, and last PUT. The block takes one command at a time, so it accepts
// no new command until the last one has written its result to the output register.
// A register write holds off the input channel in the cycle after it while the
// sequence length is rechecked.
// If the receiver stalls, the finished result waits in the output register;
// the next command may be accepted and runs, and its result is held back
// until the output register is free. Reset clears the registers to their
// defaults, stops playback and empties the output. The frame list memory has
// no reset; entries are defined once loaded.
module sprite_frame_sequencer #(
	parameter int unsigned LIST_DEPTH = sfs_pkg::LIST_DEPTH_DEF,
	parameter int unsigned MAX_FRAMES = sfs_pkg::MAX_FRAMES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  op,
	input  logic [15:0] elapsed,
	input  logic [5:0]  entry_index,
	input  logic [7:0]  entry_frame,
	input  logic        entry_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  frame_number,
	output logic [13:0] pos_x,
	output logic [13:0] pos_y,
	output logic        playing,
	output logic        done_res
);

	localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int unsigned LW = $clog2(LIST_DEPTH + 1);
	localparam int unsigned IW = (AW > 6) ? AW : 6;
	localparam int unsigned PW = sfs_pkg::PosW;
	localparam int unsigned NW = sfs_pkg::LenW;
	localparam int unsigned CW = sfs_pkg::AccW;

	logic [10:0] width_q, height_q;
	logic [4:0]  across_q, down_q;
	logic [15:0] period_q;
	logic [3:0]  mode_q;
	logic [7:0]  start_q, stop_q;

	sfs_pkg::state_t state_q;
	logic            chk_q;
	logic [CW-1:0]   acc_q;
	logic [PW-1:0]   pos_q;
	logic            run_q;
	logic [LW-1:0]   list_len_q;
	logic            done_q;
	logic            lst_q;
	logic [2:0]      cnt_q;
	logic [7:0]      fn_q;
	logic [7:0]      quo_q;
	logic [4:0]      rem_q;
	logic [13:0]     px_q, py_q;

	logic [2:0]  op_q;
	logic [15:0] elapsed_q;
	logic [5:0]  eidx_q;
	logic [7:0]  efrm_q;
	logic        elast_q;

	logic [7:0]  mem [LIST_DEPTH];
	logic [7:0]  rd_q;

	logic            out_valid_q;
	logic [7:0]      fn_out_q;
	logic [13:0]     px_out_q, py_out_q;
	logic            play_out_q, done_out_q;

	logic [4:0]    across_c, down_c;
	logic [8:0]    total_c, nsheet_c;
	logic [NW-1:0] len_c;
	logic [NW-1:0] k_c;
	logic [7:0]    seq_c;
	logic [1:0]    src_c;
	logic [7:0]    dd_c, da_c;
	logic [IW-1:0] idx_w;
	logic [AW-1:0] waddr_c, raddr_c;
	logic          mem_we_c;
	logic          idx_ok_c, k_ok_c;
	logic [17:0]   sum_c;
	logic [15:0]   per_c;
	logic [NW-1:0] pinc_c;
	logic [5:0]    trial_c;
	logic          qbit_c;
	logic [7:0]    mul_a_c;
	logic [10:0]   mul_b_c;
	logic [18:0]   prod_c;
	logic          on_sheet_c;

	always_comb begin
		across_c = sfs_pkg::clamp16(across_q);
		down_c   = sfs_pkg::clamp16(down_q);
		total_c  = 9'(across_c * down_c);
		nsheet_c = (32'(total_c) > MAX_FRAMES) ? 9'(MAX_FRAMES) : total_c;
		src_c    = mode_q[1:0];
		dd_c     = start_q - stop_q;
		da_c     = stop_q - start_q;
		unique case (src_c)
			sfs_pkg::SRC_RANGE: begin
				if (start_q == stop_q) begin
					len_c = '0;
				end else if (start_q > stop_q) begin
					len_c = mode_q[3] ? {1'b0, dd_c, 1'b0} : NW'(dd_c) + NW'(1);
				end else begin
					len_c = mode_q[3] ? {1'b0, da_c, 1'b0} - NW'(1) : NW'(da_c);
				end
			end
			sfs_pkg::SRC_LIST: len_c = NW'(list_len_q);
			default: len_c = mode_q[3] ? {nsheet_c, 1'b0} - NW'(1) : NW'(nsheet_c);
		endcase
	end

	always_comb begin
		k_c = (NW'(pos_q) < len_c) ? NW'(pos_q) : len_c - NW'(1);
		unique case (src_c)
			sfs_pkg::SRC_RANGE: begin
				if (start_q > stop_q) begin
					seq_c = (k_c <= NW'(dd_c)) ? 8'(NW'(start_q) - k_c)
						: 8'(NW'(stop_q) + (k_c - NW'(dd_c)));
				end else begin
					seq_c = (k_c < NW'(da_c)) ? 8'(NW'(start_q) + k_c)
						: 8'(NW'(stop_q) - NW'(1) - (k_c - NW'(da_c)));
				end
			end
			sfs_pkg::SRC_LIST: seq_c = 8'd0;
			default: seq_c = (k_c < NW'(nsheet_c)) ? 8'(k_c)
				: 8'({nsheet_c, 1'b0} - NW'(1) - k_c);
		endcase
		k_ok_c  = 32'(k_c) < LIST_DEPTH;
		raddr_c = k_c[AW-1:0];
	end

	always_comb begin
		idx_w    = IW'(eidx_q);
		waddr_c  = idx_w[AW-1:0];
		idx_ok_c = 32'(eidx_q) < LIST_DEPTH;
		mem_we_c = (state_q == sfs_pkg::ST_EXEC) && (op_q == sfs_pkg::OP_LOAD) && idx_ok_c;
		sum_c    = 18'(acc_q) + 18'(elapsed_q);
		per_c    = (period_q == 16'd0) ? 16'd1 : period_q;
		pinc_c   = NW'(pos_q) + NW'(1);
		trial_c  = {rem_q, quo_q[7]};
		qbit_c   = trial_c >= 6'(across_c);
		mul_a_c  = (state_q == sfs_pkg::ST_MULX) ? 8'(rem_q) : quo_q;
		mul_b_c  = (state_q == sfs_pkg::ST_MULX) ? width_q : height_q;
		prod_c   = 19'(mul_a_c) * 19'(mul_b_c);
		on_sheet_c = 9'(fn_q) < total_c;
	end

	always_ff @(posedge clk) begin
		if (mem_we_c) begin
			mem[waddr_c] <= efrm_q;
		end
		if (state_q == sfs_pkg::ST_LOOK) begin
			rd_q <= mem[raddr_c];
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q      <= op;
			elapsed_q <= elapsed;
			eidx_q    <= entry_index;
			efrm_q    <= entry_frame;
			elast_q   <= entry_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd1;
			height_q <= 11'd1;
			across_q <= 5'd1;
			down_q   <= 5'd1;
			period_q <= 16'd1;
			mode_q   <= 4'd0;
			start_q  <= 8'd0;
			stop_q   <= 8'd0;
			chk_q    <= 1'b0;
		end else begin
			chk_q <= cfg_we;
			if (cfg_we) begin
				unique case (sfs_pkg::reg_idx_t'(cfg_index))
					sfs_pkg::REG_FRAME_WIDTH:   width_q  <= cfg_data[10:0];
					sfs_pkg::REG_FRAME_HEIGHT:  height_q <= cfg_data[10:0];
					sfs_pkg::REG_FRAMES_ACROSS: across_q <= cfg_data[4:0];
					sfs_pkg::REG_FRAMES_DOWN:   down_q   <= cfg_data[4:0];
					sfs_pkg::REG_FRAME_PERIOD:  period_q <= cfg_data;
					sfs_pkg::REG_PLAY_MODE:     mode_q   <= cfg_data[3:0];
					sfs_pkg::REG_RANGE_START:   start_q  <= cfg_data[7:0];
					sfs_pkg::REG_RANGE_STOP:    stop_q   <= cfg_data[7:0];
					default: ;
				endcase
			end
		end
	end

	assign in_ready = (state_q == sfs_pkg::ST_IDLE) && !chk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sfs_pkg::ST_IDLE;
			acc_q       <= '0;
			pos_q       <= '0;
			run_q       <= 1'b0;
			list_len_q  <= '0;
			done_q      <= 1'b0;
			lst_q       <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				sfs_pkg::ST_IDLE: begin
					if (chk_q && (len_c == '0)) begin
						run_q <= 1'b0;
						pos_q <= '0;
					end
					if (in_valid && in_ready) begin
						state_q <= sfs_pkg::ST_EXEC;
					end
				end
				sfs_pkg::ST_EXEC: begin
					done_q  <= 1'b0;
					state_q <= sfs_pkg::ST_LOOK;
					unique case (op_q)
						sfs_pkg::OP_TICK: begin
							if (run_q) begin
								if (len_c == '0) begin
									run_q <= 1'b0;
									pos_q <= '0;
								end else begin
									acc_q <= (sum_c > 18'(sfs_pkg::AccMax)) ? sfs_pkg::AccMax
										: sum_c[CW-1:0];
									state_q <= sfs_pkg::ST_TCHK;
								end
							end
						end
						sfs_pkg::OP_BEGIN: begin
							if (len_c != '0) begin
								run_q <= 1'b1;
								pos_q <= '0;
							end
						end
						sfs_pkg::OP_HALT: begin
							run_q <= 1'b0;
							pos_q <= '0;
						end
						sfs_pkg::OP_PAUSE: run_q <= 1'b0;
						sfs_pkg::OP_RESUME: begin
							if (len_c != '0) begin
								run_q <= 1'b1;
							end
						end
						sfs_pkg::OP_LOAD: begin
							if (idx_ok_c && elast_q) begin
								list_len_q <= LW'(eidx_q) + LW'(1);
							end
						end
						default: ;
					endcase
				end
				sfs_pkg::ST_TCHK: begin
					if (acc_q >= CW'(per_c)) begin
						acc_q <= acc_q - CW'(per_c);
						if (pinc_c >= len_c) begin
							if (mode_q[2]) begin
								pos_q <= '0;
							end else begin
								pos_q  <= PW'(len_c - NW'(1));
								run_q  <= 1'b0;
								done_q <= 1'b1;
							end
						end else begin
							pos_q <= PW'(pinc_c);
						end
					end
					state_q <= sfs_pkg::ST_LOOK;
				end
				sfs_pkg::ST_LOOK: begin
					fn_q    <= (len_c == '0) ? 8'd0 : seq_c;
					lst_q   <= (len_c != '0) && (src_c == sfs_pkg::SRC_LIST) && k_ok_c;
					state_q <= sfs_pkg::ST_FN;
				end
				sfs_pkg::ST_FN: begin
					if (lst_q) begin
						fn_q  <= rd_q;
						quo_q <= rd_q;
					end else begin
						quo_q <= fn_q;
					end
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= sfs_pkg::ST_DIV;
				end
				sfs_pkg::ST_DIV: begin
					rem_q <= qbit_c ? 5'(trial_c - 6'(across_c)) : trial_c[4:0];
					quo_q <= {quo_q[6:0], qbit_c};
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd7) begin
						state_q <= sfs_pkg::ST_MULX;
					end
				end
				sfs_pkg::ST_MULX: begin
					px_q    <= on_sheet_c ? prod_c[13:0] : 14'd0;
					state_q <= sfs_pkg::ST_MULY;
				end
				sfs_pkg::ST_MULY: begin
					py_q    <= on_sheet_c ? prod_c[13:0] : 14'd0;
					state_q <= sfs_pkg::ST_PUT;
				end
				sfs_pkg::ST_PUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= sfs_pkg::ST_IDLE;
					end
				end
				default: state_q <= sfs_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == sfs_pkg::ST_PUT) && (!out_valid_q || out_ready)) begin
			fn_out_q   <= fn_q;
			px_out_q   <= px_q;
			py_out_q   <= py_q;
			play_out_q <= run_q;
			done_out_q <= done_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_number = fn_out_q;
	assign pos_x        = px_out_q;
	assign pos_y        = py_out_q;
	assign playing      = play_out_q;
	assign done_res     = done_out_q;

	a_done_stops: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !playing)
		else $error("done pulse delivered while playback still running");

	a_cfg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		chk_q |-> !in_ready)
		else $error("command taken before the length recheck after a register write");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == sfs_pkg::ST_EXEC)
		else $error("accepted command did not start execution");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sfs_pkg::ST_MULX |-> 6'(rem_q) < 6'(across_c))
		else $error("divider remainder not below frames across");

	a_put_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sfs_pkg::ST_PUT && out_valid_q && !out_ready |=> state_q == sfs_pkg::ST_PUT)
		else $error("result left the sequencer while the output register was full");

endmodule

### dv/sprite_frame_sequencer_tb.sv
// Self-checking testbench for the sprite frame sequencer: directed and random playback.
module sprite_frame_sequencer_tb;

	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;
	localparam int unsigned MODE_LOOP = 4'b0100;
	localparam int unsigned MODE_PINGPONG = 4'b1000;
	localparam int unsigned PixMask = 32'h3FFF;
	localparam int DrainCycles = 20;
	localparam int HoldCycles = 300;
	localparam int WatchdogLimit = 2000;
	localparam int RandPhases = 12;
	localparam int ItemsPerPhase = 75;
	localparam int QuietPhase = 6;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] elapsed;
		logic [5:0]  entry_index;
		logic [7:0]  entry_frame;
		logic        entry_last;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  frame_number;
		logic [13:0] pos_x;
		logic [13:0] pos_y;
		logic        playing;
		logic        done_res;
	} frame_res_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  op = '0;
	logic [15:0] elapsed = '0;
	logic [5:0]  entry_index = '0;
	logic [7:0]  entry_frame = '0;
	logic        entry_last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  frame_number;
	logic [13:0] pos_x;
	logic [13:0] pos_y;
	logic        playing;
	logic        done_res;

	// Shadow copy of the registers and playback state.
	int unsigned r_fw = 1, r_fh = 1, r_fa = 1, r_fd = 1, r_period = 1;
	int unsigned r_mode = 0, r_start = 0, r_stop = 0;
	int unsigned acc = 0, pos = 0, list_len = 0;
	bit          running = 1'b0;
	logic [7:0]  list_mem [64];
	bit          list_written [64] = '{default: 1'b0};

	frame_res_t  frame_q [$];
	int          errors = 0;
	int          quiet_cycles = 0;
	int          hold_left = 0;
	int          hold_reqs = 0;
	int          hold_seen = 0;
	bit          src_idle = 1'b1;
	bit          sink_idle = 1'b1;

	sprite_frame_sequencer DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .elapsed(elapsed), .entry_index(entry_index),
		.entry_frame(entry_frame), .entry_last(entry_last),
		.out_valid(out_valid), .out_ready(out_ready),
		.frame_number(frame_number), .pos_x(pos_x), .pos_y(pos_y),
		.playing(playing), .done_res(done_res)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned dim_clamp(int unsigned v);
		if (v == 0) begin
			return 1;
		end
		return (v > 16) ? 16 : v;
	endfunction

	function automatic int unsigned seq_length();
		sfs_pkg::src_t src;
		bit            pp;
		int unsigned   n;
		src = sfs_pkg::src_t'(r_mode[1:0]);
		pp = (r_mode & MODE_PINGPONG) != 0;
		if (src == sfs_pkg::SRC_RANGE) begin
			if (r_start == r_stop) begin
				return 0;
			end
			if (r_start > r_stop) begin
				return pp ? 2 * (r_start - r_stop) : r_start - r_stop + 1;
			end
			return pp ? 2 * (r_stop - r_start) - 1 : r_stop - r_start;
		end
		if (src == sfs_pkg::SRC_LIST) begin
			return list_len;
		end
		n = dim_clamp(r_fa) * dim_clamp(r_fd);
		return pp ? 2 * n - 1 : n;
	endfunction

	function automatic int unsigned seq_frame(int unsigned k);
		sfs_pkg::src_t src;
		int unsigned   d;
		int unsigned   n;
		src = sfs_pkg::src_t'(r_mode[1:0]);
		if (src == sfs_pkg::SRC_RANGE) begin
			if (r_start > r_stop) begin
				d = r_start - r_stop;
				return (k <= d) ? r_start - k : r_stop + (k - d);
			end
			d = r_stop - r_start;
			return (k < d) ? r_start + k : r_stop - 1 - (k - d);
		end
		if (src == sfs_pkg::SRC_LIST) begin
			return 32'(list_mem[k]);
		end
		n = dim_clamp(r_fa) * dim_clamp(r_fd);
		return (k < n) ? k : 2 * n - 1 - k;
	endfunction

	function automatic frame_res_t predict_frame(cmd_t c);
		frame_res_t  r;
		int unsigned len, per, k, fn, cols, px, py;
		r = '0;
		len = seq_length();
		case (c.op)
			sfs_pkg::OP_TICK: begin
				if (running && len == 0) begin
					running = 1'b0;
					pos = 0;
				end else if (running) begin
					per = (r_period == 0) ? 1 : r_period;
					acc = acc + 32'(c.elapsed);
					if (acc > 32'(sfs_pkg::AccMax)) begin
						acc = 32'(sfs_pkg::AccMax);
					end
					if (acc >= per) begin
						acc = acc - per;
						pos = pos + 1;
						if (pos >= len) begin
							if ((r_mode & MODE_LOOP) != 0) begin
								pos = 0;
							end else begin
								pos = len - 1;
								running = 1'b0;
								r.done_res = 1'b1;
							end
						end
					end
				end
			end
			sfs_pkg::OP_BEGIN: begin
				if (len != 0) begin
					running = 1'b1;
					pos = 0;
				end
			end
			sfs_pkg::OP_HALT: begin
				running = 1'b0;
				pos = 0;
			end
			sfs_pkg::OP_PAUSE: running = 1'b0;
			sfs_pkg::OP_RESUME: begin
				if (len != 0) begin
					running = 1'b1;
				end
			end
			sfs_pkg::OP_LOAD: begin
				list_mem[c.entry_index] = c.entry_frame;
				list_written[c.entry_index] = 1'b1;
				if (c.entry_last) begin
					list_len = 32'(c.entry_index) + 1;
				end
			end
			default: ;
		endcase
		len = seq_length();
		if (len != 0) begin
			k = (pos < len) ? pos : len - 1;
			cols = dim_clamp(r_fa);
			fn = seq_frame(k);
			r.frame_number = fn[7:0];
			if (fn < cols * dim_clamp(r_fd)) begin
				px = ((fn % cols) * r_fw) & PixMask;
				py = ((fn / cols) * r_fh) & PixMask;
				r.pos_x = px[13:0];
				r.pos_y = py[13:0];
			end
		end
		r.playing = running;
		return r;
	endfunction

	function automatic cmd_t make_cmd(logic [2:0] o, logic [15:0] el = '0, logic [5:0] ix = '0,
			logic [7:0] fr = '0, logic la = 1'b0);
		cmd_t c;
		c.op = o;
		c.elapsed = el;
		c.entry_index = ix;
		c.entry_frame = fr;
		c.entry_last = la;
		return c;
	endfunction

	task automatic send_cmd(cmd_t c);
		if (src_idle && $urandom_range(99) < 13) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 40);
		end
		in_valid <= 1'b1;
		op <= c.op;
		elapsed <= c.elapsed;
		entry_index <= c.entry_index;
		entry_frame <= c.entry_frame;
		entry_last <= c.entry_last;
		do @(posedge clk); while (!in_ready);
		frame_q.insert(frame_q.size(), predict_frame(c));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (frame_q.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(sfs_pkg::reg_idx_t idx, int unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[15:0];
		case (idx)
			sfs_pkg::REG_FRAME_WIDTH:   r_fw = val & 32'h7FF;
			sfs_pkg::REG_FRAME_HEIGHT:  r_fh = val & 32'h7FF;
			sfs_pkg::REG_FRAMES_ACROSS: r_fa = val & 32'h1F;
			sfs_pkg::REG_FRAMES_DOWN:   r_fd = val & 32'h1F;
			sfs_pkg::REG_FRAME_PERIOD:  r_period = val & 32'hFFFF;
			sfs_pkg::REG_PLAY_MODE:     r_mode = val & 32'hF;
			sfs_pkg::REG_RANGE_START:   r_start = val & 32'hFF;
			sfs_pkg::REG_RANGE_STOP:    r_stop = val & 32'hFF;
			default: ;
		endcase
		if (seq_length() == 0) begin
			running = 1'b0;
			pos = 0;
		end
		@(posedge clk);
	endtask

	task automatic configure(input int unsigned fw, fh, fa, fd, per, mode, rs, re);
		write_reg(sfs_pkg::REG_FRAME_WIDTH, fw);
		write_reg(sfs_pkg::REG_FRAME_HEIGHT, fh);
		write_reg(sfs_pkg::REG_FRAMES_ACROSS, fa);
		write_reg(sfs_pkg::REG_FRAMES_DOWN, fd);
		write_reg(sfs_pkg::REG_FRAME_PERIOD, per);
		write_reg(sfs_pkg::REG_PLAY_MODE, mode);
		write_reg(sfs_pkg::REG_RANGE_START, rs);
		write_reg(sfs_pkg::REG_RANGE_STOP, re);
		cfg_we <= 1'b0;
	endtask

	function automatic int unsigned pick_pixels();
		case ($urandom_range(5))
			0: return 0;
			1: return 1;
			2: return 1024;
			3: return 2047;
			default: return $urandom_range(1, 1024);
		endcase
	endfunction

	function automatic int unsigned pick_dim();
		case ($urandom_range(5))
			0: return 0;
			1: return 1;
			2: return 16;
			3: return 31;
			default: return $urandom_range(1, 16);
		endcase
	endfunction

	task automatic test_default_playback();
		send_cmd(make_cmd(sfs_pkg::OP_BEGIN));
		send_cmd(make_cmd(sfs_pkg::OP_TICK, 16'h0000));
		send_cmd(make_cmd(sfs_pkg::OP_TICK, 16'hFFFF));
		send_cmd(make_cmd(sfs_pkg::OP_TICK, 16'h0001));
		send_cmd(make_cmd(sfs_pkg::OP_RESUME));
		send_cmd(make_cmd(sfs_pkg::OP_PAUSE));
		send_cmd(make_cmd(OP_SPARE6, 16'hFFFF, 6'h3F, 8'hFF, 1'b1));
		send_cmd(make_cmd(OP_SPARE7, 16'hFFFF, 6'h3F, 8'hFF, 1'b1));
		send_cmd(make_cmd(sfs_pkg::OP_HALT));
		drain();
	endtask

	task automatic test_list_playback();
		configure(2047, 1024, 31, 3, 0, sfs_pkg::SRC_LIST | MODE_LOOP, 0, 0);
		send_cmd(make_cmd(sfs_pkg::OP_LOAD, 16'h0, 6'd0, 8'd0, 1'b0));
		send_cmd(make_cmd(sfs_pkg::OP_LOAD, 16'h0, 6'd1, 8'd255, 1'b0));
		send_cmd(make_cmd(sfs_pkg::OP_LOAD, 16'h0, 6'd2, 8'd47, 1'b1));
		send_cmd(make_cmd(sfs_pkg::OP_LOAD, 16'h0, 6'd63, 8'hA5, 1'b0));
		send_cmd(make_cmd(sfs_pkg::OP_BEGIN));
		repeat (3) send_cmd(make_cmd(sfs_pkg::OP_TICK, 16'd1));
		drain();
	endtask

	task automatic test_empty_range();
		configure(3, 5, 16, 16, 1, sfs_pkg::SRC_RANGE, 200, 200);
		send_cmd(make_cmd(sfs_pkg::OP_BEGIN));
		send_cmd(make_cmd(sfs_pkg::OP_RESUME));
		send_cmd(make_cmd(sfs_pkg::OP_TICK, 16'd5));
		drain();
	endtask

	task automatic test_stale_position();
		configure(7, 9, 4, 4, 1, sfs_pkg::SRC_SHEET, 0, 0);
		send_cmd(make_cmd(sfs_pkg::OP_BEGIN));
		repeat (5) send_cmd(make_cmd(sfs_pkg::OP_TICK, 16'd1));
		drain();
		configure(7, 9, 1, 2, 1, sfs_pkg::SRC_SHEET, 0, 0);
		send_cmd(make_cmd(OP_SPARE6));
		send_cmd(make_cmd(sfs_pkg::OP_TICK, 16'd1));
		drain();
	endtask

	task automatic test_output_backpressure();
		configure(16, 16, 16, 16, 1, sfs_pkg::SRC_SHEET | MODE_LOOP, 0, 0);
		send_cmd(make_cmd(sfs_pkg::OP_BEGIN));
		hold_reqs++;
		repeat (30) send_cmd(make_cmd(sfs_pkg::OP_TICK, 16'd1));
		drain();
	endtask

	task automatic run_random_items(int n);
		int          sent;
		int unsigned r, lim, list_n;
		bit          prefix_ok;
		cmd_t        c;
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(99);
			c.op = sfs_pkg::OP_TICK;
			c.elapsed = 16'($urandom);
			c.entry_index = 6'($urandom);
			c.entry_frame = 8'($urandom);
			c.entry_last = 1'($urandom);
			if (r >= 95) begin
				list_n = ($urandom_range(3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 6);
				for (int i = 0; i < list_n; i++) begin
					send_cmd(make_cmd(sfs_pkg::OP_LOAD, 16'($urandom), 6'(i), 8'($urandom),
						i == list_n - 1));
				end
				sent = sent + list_n;
			end else begin
				if (r < 70) begin
					lim = (r_period == 0) ? 2 : 2 * r_period;
					if (lim > 65535) begin
						lim = 65535;
					end
					case ($urandom_range(9))
						8: c.elapsed = 16'($urandom);
						9: c.elapsed = $urandom_range(1) ? 16'hFFFF : 16'h0000;
						default: c.elapsed = 16'($urandom_range(0, lim));
					endcase
				end else if (r < 75) begin
					c.op = sfs_pkg::OP_BEGIN;
				end else if (r < 78) begin
					c.op = sfs_pkg::OP_HALT;
				end else if (r < 81) begin
					c.op = sfs_pkg::OP_PAUSE;
				end else if (r < 86) begin
					c.op = sfs_pkg::OP_RESUME;
				end else if (r < 88) begin
					c.op = $urandom_range(1) ? OP_SPARE6 : OP_SPARE7;
				end else begin
					// A list end may only be set once every entry below it holds a frame.
					c.op = sfs_pkg::OP_LOAD;
					prefix_ok = 1'b1;
					for (int i = 0; i < c.entry_index; i++) begin
						prefix_ok = prefix_ok & list_written[i];
					end
					c.entry_last = c.entry_last & prefix_ok;
				end
				send_cmd(c);
				sent = sent + 1;
			end
		end
	endtask

	task automatic test_random_phases();
		int unsigned fw, fh, fa, fd, per, mode, rs, re;
		for (int p = 0; p < RandPhases; p++) begin
			if (p == 0) begin
				fw = 2047; fh = 2047; fa = 31; fd = 31; per = 1;
				mode = sfs_pkg::SRC_RANGE | MODE_LOOP | MODE_PINGPONG; rs = 255; re = 0;
			end else if (p == 1) begin
				fw = 0; fh = 1; fa = 0; fd = 0; per = 0;
				mode = sfs_pkg::SRC_RANGE | MODE_LOOP; rs = 0; re = 1;
			end else begin
				fw = pick_pixels();
				fh = pick_pixels();
				fa = pick_dim();
				fd = pick_dim();
				case ($urandom_range(9))
					6: per = 0;
					7: per = 65535;
					8, 9: per = $urandom_range(1, 65535);
					default: per = $urandom_range(1, 6);
				endcase
				mode = $urandom_range(15);
				rs = $urandom_range(255);
				if ($urandom_range(1) == 0) begin
					re = $urandom_range(rs > 12 ? rs - 12 : 0, rs + 12 > 255 ? 255 : rs + 12);
				end else begin
					re = $urandom_range(255);
				end
			end
			src_idle = (p != QuietPhase);
			sink_idle = (p != QuietPhase);
			configure(fw, fh, fa, fd, per, mode, rs, re);
			run_random_items(ItemsPerPhase);
			drain();
		end
		src_idle = 1'b1;
		sink_idle = 1'b1;
	endtask

	always @(posedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen = hold_reqs;
			hold_left = HoldCycles;
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !(sink_idle && $urandom_range(99) < 13);
		end
	end

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		frame_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (frame_q.size() == 0) begin
				errors++;
				$display("%0t: result beat with none expected, actual frame %0d", $time,
					frame_number);
			end else begin
				want = frame_q.pop_front();
				check_field("frame_number", want.frame_number, frame_number);
				check_field("pos_x", want.pos_x, pos_x);
				check_field("pos_y", want.pos_y, pos_y);
				check_field("playing", want.playing, playing);
				check_field("done_res", want.done_res, done_res);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WatchdogLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_playback();
		test_list_playback();
		test_empty_range();
		test_stale_position();
		test_output_backpressure();
		test_random_phases();
		drain();
		errors += frame_q.size();
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
